// ----- design/gqtn_pkg.sv -----
// Shared widths, types and register codes for the grid quad triangulator.
package gqtn_pkg;

    localparam int IDX_W      = 20;
    localparam int COL_W      = 10;
    localparam int HGT_W      = 16;
    localparam int NRM_W      = 16;
    localparam int COLS_W     = 11;
    localparam int SPC_W      = 16;
    localparam int PROD_W     = 32;
    localparam int MAG_W      = 31;
    localparam int SQ_W       = 62;
    localparam int SUM_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int SQ_REM_W   = 35;
    localparam int QUO_W      = 15;
    localparam int FRAC_W     = 14;
    localparam int DIV_W      = 46;
    localparam int SH_W       = 5;
    localparam int CFG_IDX_W  = 2;

    localparam logic [NRM_W-1:0] NRM_ONE = 16'd16384;

    // Register indexes on the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_COLUMNS = 2'd0,
        CFG_SPACING_X    = 2'd1,
        CFG_SPACING_Z    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] second;
        logic [IDX_W-1:0] third;
        logic             last;
    } tri_idx_t;

    typedef struct packed {
        tri_idx_t   idx;
        logic       degen;
        logic [2:0] neg;
    } tri_side_t;

    typedef struct packed {
        tri_side_t                 side;
        logic [2:0][MAG_W-1:0]     mag;
    } norm_side_t;

endpackage

// ----- design/grid_quad_triangulate_normal_top.sv -----
// Top level of the grid quad triangulator with face normals.
//
// Input stream (s_axis): one request per grid quad: column, row and four
// corner heights. Output stream (m_axis): two triangle requests per quad,
// first (tl, bl, br) with tlast low, then (tl, br, tr) with tlast high,
// each with three vertex indices and a unit normal in signed Q1.14.
// Config port: cfg_we / cfg_index / cfg_data, written by the user only while idle; the block does not enforce this.
//
// Throughput: one triangle per cycle while the receiver does not stall;
// the quad holding stage issues the two triangles back to back and takes
// the next quad as it issues the second. The pipeline depth is set by
// the 32-stage square root and the 16-stage divider (a rounding stage,
// then one quotient bit per stage).
// Reset clears every valid bit and loads the registers with 2 columns and
// spacings of 1.0. When the receiver stalls, the whole pipeline holds in
// place and s_axis_tready drops; nothing is lost or repeated.
module grid_quad_triangulate_normal_top #(
    parameter int MAX_GRID = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [gqtn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gqtn_pkg::SPC_W-1:0]         cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // quad_column, quad_row, height_top_left, height_top_right,
    // height_bottom_left, height_bottom_right, 4 zero bits
    input  logic [87:0]                        s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // vertex_first, vertex_second, vertex_third, normal_x, normal_y,
    // normal_z, 4 zero bits
    output logic [111:0]                       m_axis_tdata,
    output logic                               m_axis_tlast
);
    import gqtn_pkg::*;

    logic [COLS_W-1:0]  cols_reg;
    logic [SPC_W-1:0]   spacing_x_reg;
    logic [SPC_W-1:0]   spacing_z_reg;

    logic               adv;
    logic               fr_valid;
    tri_idx_t           fr_idx;
    logic [2:0]         fr_neg;
    logic [2:0][PROD_W-1:0] fr_prod;
    logic               nm_valid;
    norm_side_t         nm_side;
    logic [SUM_W-1:0]   nm_sum;
    logic               sq_valid;
    logic [ROOT_W-1:0]  sq_root;
    norm_side_t         sq_side;
    logic               dv_valid;
    logic [2:0][QUO_W-1:0] dv_quo;
    tri_side_t          dv_side;

    logic               out_valid_reg;
    tri_idx_t           out_idx_reg;
    logic [2:0][NRM_W-1:0] out_nrm_reg;
    logic [2:0][NRM_W-1:0] nrm;

    assign adv = !out_valid_reg || m_axis_tready;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg      <= COLS_W'(2);
            spacing_x_reg <= SPC_W'(256);
            spacing_z_reg <= SPC_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_COLUMNS:
                begin
                    if (int'(cfg_data[COLS_W-1:0]) > MAX_GRID)
                        cols_reg <= COLS_W'(MAX_GRID);
                    else
                        cols_reg <= cfg_data[COLS_W-1:0];
                end
                CFG_SPACING_X: spacing_x_reg <= cfg_data;
                CFG_SPACING_Z: spacing_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    gqtn_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .adv                 (adv),
        .grid_columns        (cols_reg),
        .spacing_x           (spacing_x_reg),
        .spacing_z           (spacing_z_reg),
        .in_valid            (s_axis_tvalid),
        .in_ready            (s_axis_tready),
        .quad_column         (s_axis_tdata[9:0]),
        .quad_row            (s_axis_tdata[19:10]),
        .height_top_left     (s_axis_tdata[35:20]),
        .height_top_right    (s_axis_tdata[51:36]),
        .height_bottom_left  (s_axis_tdata[67:52]),
        .height_bottom_right (s_axis_tdata[83:68]),
        .out_valid           (fr_valid),
        .out_idx             (fr_idx),
        .out_neg             (fr_neg),
        .out_prod            (fr_prod)
    );

    gqtn_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_idx    (fr_idx),
        .in_neg    (fr_neg),
        .in_prod   (fr_prod),
        .out_valid (nm_valid),
        .out_side  (nm_side),
        .out_sum   (nm_sum)
    );

    gqtn_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (nm_valid),
        .in_sum    (nm_sum),
        .in_side   (nm_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    gqtn_div3 u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_len    (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // Apply signs; a zero cross product points straight up
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_side.neg[i])
                nrm[i] = NRM_W'(0) - NRM_W'(dv_quo[i]);
            else
                nrm[i] = NRM_W'(dv_quo[i]);
        end
        if (dv_side.degen)
        begin
            nrm[0] = '0;
            nrm[1] = NRM_ONE;
            nrm[2] = '0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_idx_reg <= dv_side.idx;
            out_nrm_reg <= nrm;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_idx_reg.last;
    assign m_axis_tdata  = {4'b0000, out_nrm_reg[2], out_nrm_reg[1], out_nrm_reg[0],
                            out_idx_reg.third, out_idx_reg.second, out_idx_reg.first};

endmodule

// ----- design/gqtn_front.sv -----
// Quad holding stage, triangle split, vertex indices and cross product terms.
module gqtn_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic [gqtn_pkg::COLS_W-1:0]   grid_columns,
    input  logic [gqtn_pkg::SPC_W-1:0]    spacing_x,
    input  logic [gqtn_pkg::SPC_W-1:0]    spacing_z,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gqtn_pkg::COL_W-1:0]    quad_column,
    input  logic [gqtn_pkg::COL_W-1:0]    quad_row,
    input  logic [gqtn_pkg::HGT_W-1:0]    height_top_left,
    input  logic [gqtn_pkg::HGT_W-1:0]    height_top_right,
    input  logic [gqtn_pkg::HGT_W-1:0]    height_bottom_left,
    input  logic [gqtn_pkg::HGT_W-1:0]    height_bottom_right,
    output logic                          out_valid,
    output gqtn_pkg::tri_idx_t            out_idx,
    output logic [2:0]                    out_neg,
    output logic [2:0][gqtn_pkg::PROD_W-1:0] out_prod
);
    import gqtn_pkg::*;

    logic                 hold_valid_reg;
    logic                 phase_reg;
    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     row_reg;
    logic [HGT_W-1:0]     htl_reg, htr_reg, hbl_reg, hbr_reg;

    logic                 s1_valid_reg;
    logic                 s1_last_reg;
    logic [IDX_W-1:0]     s1_tl_reg;
    logic [HGT_W-1:0]     s1_mag_a_reg, s1_mag_b_reg;
    logic                 s1_neg_a_reg, s1_neg_b_reg;

    logic                 s2_valid_reg;
    tri_idx_t             s2_idx_reg;
    logic [2:0]           s2_neg_reg;
    logic [2:0][PROD_W-1:0] s2_prod_reg;

    logic                 accept;
    logic [HGT_W-1:0]     pa, pb, qa, qb;
    logic [HGT_W-1:0]     mag_a, mag_b;
    logic [IDX_W:0]       tl_full;
    logic [IDX_W-1:0]     tr, bl, br;

    assign in_ready = adv && (!hold_valid_reg || phase_reg);
    assign accept   = in_valid && in_ready;

    // Height differences: first triangle uses (bl-br, tl-bl), second (tl-tr, tr-br)
    always_comb
    begin
        pa      = phase_reg ? htl_reg : hbl_reg;
        pb      = phase_reg ? htr_reg : hbr_reg;
        qa      = phase_reg ? htr_reg : htl_reg;
        qb      = phase_reg ? hbr_reg : hbl_reg;
        mag_a   = (pa >= pb) ? (pa - pb) : (pb - pa);
        mag_b   = (qa >= qb) ? (qa - qb) : (qb - qa);
        tl_full = (IDX_W+1)'(row_reg) * (IDX_W+1)'(grid_columns) + (IDX_W+1)'(col_reg);
    end

    // Neighbor indices, wrapped to the index width
    always_comb
    begin
        tr = s1_tl_reg + IDX_W'(1);
        bl = s1_tl_reg + IDX_W'(grid_columns);
        br = bl + IDX_W'(1);
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= hold_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            if (accept)
            begin
                hold_valid_reg <= 1'b1;
                phase_reg      <= 1'b0;
            end
            else if (hold_valid_reg)
            begin
                if (phase_reg)
                    hold_valid_reg <= 1'b0;
                else
                    phase_reg <= 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (accept)
            begin
                col_reg <= quad_column;
                row_reg <= quad_row;
                htl_reg <= height_top_left;
                htr_reg <= height_top_right;
                hbl_reg <= height_bottom_left;
                hbr_reg <= height_bottom_right;
            end
            s1_last_reg  <= phase_reg;
            s1_tl_reg    <= tl_full[IDX_W-1:0];
            s1_mag_a_reg <= mag_a;
            s1_mag_b_reg <= mag_b;
            s1_neg_a_reg <= pa < pb;
            s1_neg_b_reg <= qa < qb;

            s2_idx_reg.first  <= s1_tl_reg;
            s2_idx_reg.second <= s1_last_reg ? br : bl;
            s2_idx_reg.third  <= s1_last_reg ? tr : br;
            s2_idx_reg.last   <= s1_last_reg;
            s2_neg_reg        <= {s1_neg_b_reg, 1'b0, s1_neg_a_reg};
            s2_prod_reg[0]    <= PROD_W'(spacing_z) * PROD_W'(s1_mag_a_reg);
            s2_prod_reg[1]    <= PROD_W'(spacing_x) * PROD_W'(spacing_z);
            s2_prod_reg[2]    <= PROD_W'(spacing_x) * PROD_W'(s1_mag_b_reg);
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_idx   = s2_idx_reg;
    assign out_neg   = s2_neg_reg;
    assign out_prod  = s2_prod_reg;

endmodule

// ----- design/gqtn_norm.sv -----
// Common scaling of the cross product and sum of squares.
module gqtn_norm (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  logic                             in_valid,
    input  gqtn_pkg::tri_idx_t               in_idx,
    input  logic [2:0]                       in_neg,
    input  logic [2:0][gqtn_pkg::PROD_W-1:0] in_prod,
    output logic                             out_valid,
    output gqtn_pkg::norm_side_t             out_side,
    output logic [gqtn_pkg::SUM_W-1:0]       out_sum
);
    import gqtn_pkg::*;

    logic [4:0]              vld_reg;
    tri_idx_t                n1_idx_reg, n2_idx_reg;
    logic [2:0]              n1_neg_reg, n2_neg_reg;
    logic [2:0][PROD_W-1:0]  n1_prod_reg, n2_prod_reg;
    logic [PROD_W-1:0]       n1_big_reg;
    logic                    n2_degen_reg;
    logic                    n2_right_reg;
    logic [SH_W-1:0]         n2_lsh_reg;
    norm_side_t              n3_side_reg, n4_side_reg, n5_side_reg;
    logic [2:0][SQ_W-1:0]    n4_sq_reg;
    logic [SUM_W-1:0]        n5_sum_reg;

    logic [PROD_W-1:0]       big;
    logic [SH_W-1:0]         lsh;
    logic [2:0][MAG_W-1:0]   scaled;

    // Largest magnitude
    always_comb
    begin
        big = in_prod[0];
        if (in_prod[1] > big)
            big = in_prod[1];
        if (in_prod[2] > big)
            big = in_prod[2];
    end

    // Left shift that brings the top bit to position 30
    always_comb
    begin
        lsh = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (n1_big_reg[i])
                lsh = SH_W'(MAG_W - 1 - i);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (n2_right_reg)
                scaled[i] = n2_prod_reg[i][PROD_W-1:1];
            else
                scaled[i] = n2_prod_reg[i][MAG_W-1:0] << n2_lsh_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n1_idx_reg  <= in_idx;
            n1_neg_reg  <= in_neg;
            n1_prod_reg <= in_prod;
            n1_big_reg  <= big;

            n2_idx_reg   <= n1_idx_reg;
            n2_neg_reg   <= n1_neg_reg;
            n2_prod_reg  <= n1_prod_reg;
            n2_degen_reg <= (n1_big_reg == '0);
            n2_right_reg <= n1_big_reg[PROD_W-1];
            n2_lsh_reg   <= lsh;

            n3_side_reg.side.idx   <= n2_idx_reg;
            n3_side_reg.side.neg   <= n2_neg_reg;
            n3_side_reg.side.degen <= n2_degen_reg;
            n3_side_reg.mag        <= scaled;

            n4_side_reg <= n3_side_reg;
            for (int i = 0; i < 3; i++)
                n4_sq_reg[i] <= SQ_W'(n3_side_reg.mag[i]) * SQ_W'(n3_side_reg.mag[i]);

            n5_side_reg <= n4_side_reg;
            n5_sum_reg  <= SUM_W'(n4_sq_reg[0]) + SUM_W'(n4_sq_reg[1])
                         + SUM_W'(n4_sq_reg[2]);
        end
    end

    assign out_valid = vld_reg[4];
    assign out_side  = n5_side_reg;
    assign out_sum   = n5_sum_reg;

endmodule

// ----- design/gqtn_isqrt.sv -----
// Pipelined integer square root, one root bit per stage.
module gqtn_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [gqtn_pkg::SUM_W-1:0]  in_sum,
    input  gqtn_pkg::norm_side_t        in_side,
    output logic                        out_valid,
    output logic [gqtn_pkg::ROOT_W-1:0] out_root,
    output gqtn_pkg::norm_side_t        out_side
);
    import gqtn_pkg::*;

    localparam int STEPS = ROOT_W;

    logic [STEPS-1:0]     vld_reg;
    logic [SQ_REM_W-1:0]  rem_reg  [STEPS];
    logic [ROOT_W-1:0]    root_reg [STEPS];
    logic [SUM_W-1:0]     val_reg  [STEPS];
    norm_side_t           side_reg [STEPS];

    logic [SQ_REM_W-1:0]  rem_next  [STEPS];
    logic [ROOT_W-1:0]    root_next [STEPS];
    logic [SUM_W-1:0]     val_next  [STEPS];

    // One restoring step per stage: bring down two bits, try (2r << 1) | 1
    always_comb
    begin
        logic [SQ_REM_W-1:0] src_rem;
        logic [ROOT_W-1:0]   src_root;
        logic [SUM_W-1:0]    src_val;
        logic [SQ_REM_W-1:0] rem_sh;
        logic [SQ_REM_W-1:0] trial;
        for (int k = 0; k < STEPS; k++)
        begin
            src_rem  = (k == 0) ? '0 : rem_reg[(k == 0) ? 0 : k-1];
            src_root = (k == 0) ? '0 : root_reg[(k == 0) ? 0 : k-1];
            src_val  = (k == 0) ? in_sum : val_reg[(k == 0) ? 0 : k-1];
            rem_sh   = {src_rem[SQ_REM_W-3:0], src_val[SUM_W-1:SUM_W-2]};
            trial    = SQ_REM_W'({src_root, 2'b01});
            if (rem_sh >= trial)
            begin
                rem_next[k]  = rem_sh - trial;
                root_next[k] = {src_root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rem_sh;
                root_next[k] = {src_root[ROOT_W-2:0], 1'b0};
            end
            val_next[k] = {src_val[SUM_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[STEPS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                val_reg[k]  <= val_next[k];
                side_reg[k] <= (k == 0) ? in_side : side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign out_root  = root_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

// ----- design/gqtn_div3.sv -----
// Three-lane pipelined divider: (mag * 2^14 + len/2) / len, one quotient bit per stage.
module gqtn_div3 (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic [gqtn_pkg::ROOT_W-1:0]         in_len,
    input  gqtn_pkg::norm_side_t                in_side,
    output logic                                out_valid,
    output logic [2:0][gqtn_pkg::QUO_W-1:0]     out_quo,
    output gqtn_pkg::tri_side_t                 out_side
);
    import gqtn_pkg::*;

    localparam int STEPS = QUO_W;

    logic                   prep_vld_reg;
    logic [2:0][DIV_W-1:0]  prep_num_reg;
    logic [ROOT_W-1:0]      prep_len_reg;
    tri_side_t              prep_side_reg;

    logic [STEPS-1:0]       vld_reg;
    logic [2:0][DIV_W-1:0]  rem_reg  [STEPS];
    logic [2:0][QUO_W-1:0]  quo_reg  [STEPS];
    logic [ROOT_W-1:0]      len_reg  [STEPS];
    tri_side_t              side_reg [STEPS];

    logic [2:0][DIV_W-1:0]  rem_next [STEPS];
    logic [2:0][QUO_W-1:0]  quo_next [STEPS];

    // Compare and subtract the shifted divisor, one lane each
    always_comb
    begin
        logic [2:0][DIV_W-1:0] src_rem;
        logic [2:0][QUO_W-1:0] src_quo;
        logic [ROOT_W-1:0]     src_len;
        logic [DIV_W-1:0]      dsh;
        for (int k = 0; k < STEPS; k++)
        begin
            src_rem = (k == 0) ? prep_num_reg : rem_reg[(k == 0) ? 0 : k-1];
            src_quo = (k == 0) ? '0 : quo_reg[(k == 0) ? 0 : k-1];
            src_len = (k == 0) ? prep_len_reg : len_reg[(k == 0) ? 0 : k-1];
            dsh     = DIV_W'(src_len) << (STEPS - 1 - k);
            for (int i = 0; i < 3; i++)
            begin
                if (src_rem[i] >= dsh)
                begin
                    rem_next[k][i] = src_rem[i] - dsh;
                    quo_next[k][i] = {src_quo[i][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k][i] = src_rem[i];
                    quo_next[k][i] = {src_quo[i][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_vld_reg <= 1'b0;
            vld_reg      <= '0;
        end
        else if (adv)
        begin
            prep_vld_reg <= in_valid;
            vld_reg      <= {vld_reg[STEPS-2:0], prep_vld_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Rounded numerator
            for (int i = 0; i < 3; i++)
                prep_num_reg[i] <= (DIV_W'(in_side.mag[i]) << FRAC_W)
                                 + DIV_W'(in_len[ROOT_W-1:1]);
            prep_len_reg  <= in_len;
            prep_side_reg <= in_side.side;
            for (int k = 0; k < STEPS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                quo_reg[k]  <= quo_next[k];
                len_reg[k]  <= (k == 0) ? prep_len_reg : len_reg[(k == 0) ? 0 : k-1];
                side_reg[k] <= (k == 0) ? prep_side_reg : side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign out_quo   = quo_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

// ----- design/gqtn_checker.sv -----
// Port-level checks for the grid quad triangulator, bound to the top level.
module gqtn_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata,
    input logic         m_axis_tlast
);

    // No result request while in reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result request during reset");

    // A stalled result request holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // A quad yields two triangles, so input is closed the cycle after a take
    a_two_per_quad: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("quad taken while previous one still splitting");

    // Vertical normal component is never negative and never above one
    a_normal_y: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[91] && (m_axis_tdata[90:76] <= 15'd16384))
        else $error("normal_y out of range");

endmodule

bind grid_quad_triangulate_normal_top gqtn_checker u_gqtn_checker (.*);

// ----- test/grid_quad_triangulate_normal_top_tb.sv -----
// Self-checking testbench for the grid quad triangulator with face normals.
`timescale 1ns / 1ps

module grid_quad_triangulate_normal_top_tb;
    import gqtn_pkg::*;

    localparam int GRID_LIMIT    = 1024;
    localparam int DRAIN_CYCLES  = 80;
    localparam int STALL_LIMIT   = 5000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] second;
        logic [IDX_W-1:0] third;
        logic [NRM_W-1:0] nx;
        logic [NRM_W-1:0] ny;
        logic [NRM_W-1:0] nz;
        logic             last;
    } triangle_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SPC_W-1:0]     cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [87:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;
    logic         m_axis_tlast;

    // Shadow registers of the block
    longint unsigned columns_q;
    longint unsigned step_x_q;
    longint unsigned step_z_q;

    triangle_t triangles_due[$];
    int        mismatch_count;
    int        quiet;
    int        stall_cycles;
    bit        in_hit;
    bit        out_hit;

    grid_quad_triangulate_normal_top dut (.*);

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Integer square root, floor
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // One triangle: indices plus normalized cross product
    function automatic triangle_t face(longint unsigned a, longint unsigned b,
                                       longint unsigned c, longint cx, longint cy,
                                       longint cz, bit last);
        triangle_t t;
        longint unsigned m[3];
        bit neg[3];
        longint unsigned big;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned n;
        logic [NRM_W-1:0] comp[3];
        longint c3[3];
        c3[0] = cx;
        c3[1] = cy;
        c3[2] = cz;
        t.first  = a[IDX_W-1:0];
        t.second = b[IDX_W-1:0];
        t.third  = c[IDX_W-1:0];
        t.last   = last;
        big = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = c3[i] < 0;
            m[i] = neg[i] ? -c3[i] : c3[i];
            if (m[i] > big)
                big = m[i];
        end
        if (big == 0)
        begin
            t.nx = '0;
            t.ny = NRM_ONE;
            t.nz = '0;
            return t;
        end
        while (big >= (64'd1 << 31))
        begin
            for (int i = 0; i < 3; i++)
                m[i] = m[i] >> 1;
            big = big >> 1;
        end
        while (big < (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++)
                m[i] = m[i] << 1;
            big = big << 1;
        end
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = root_floor(sum);
        for (int i = 0; i < 3; i++)
        begin
            n = (m[i] * 16384 + (len >> 1)) / len;
            comp[i] = neg[i] ? -n[NRM_W-1:0] : n[NRM_W-1:0];
        end
        t.nx = comp[0];
        t.ny = comp[1];
        t.nz = comp[2];
        return t;
    endfunction

    // Queue both triangles of an accepted quad
    task automatic predict_quad(logic [87:0] d);
        longint unsigned col;
        longint unsigned row;
        longint htl, htr, hbl, hbr, sx, sz;
        longint unsigned tl, tr, bl, br;
        col = d[9:0];
        row = d[19:10];
        htl = d[35:20];
        htr = d[51:36];
        hbl = d[67:52];
        hbr = d[83:68];
        sx = step_x_q;
        sz = step_z_q;
        tl = row * columns_q + col;
        tr = tl + 1;
        bl = tl + columns_q;
        br = bl + 1;
        triangles_due.push_back(face(tl, bl, br, sz * (hbl - hbr), sx * sz,
                                     -(sx * (hbl - htl)), 1'b0));
        triangles_due.push_back(face(tl, br, tr, -(sz * (htr - htl)), sx * sz,
                                     sx * (htr - hbr), 1'b1));
    endtask

    // Send one quad; returns at the edge that took it
    task automatic send_quad(logic [9:0] col, logic [9:0] row, logic [15:0] htl,
                             logic [15:0] htr, logic [15:0] hbl, logic [15:0] hbr);
        logic [87:0] d;
        d = {4'b0, hbr, hbl, htr, htl, row, col};
        while (quiet == 0 && $urandom_range(0, 99) < 8)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        forever
        begin
            @(negedge clk);
            if (s_axis_tready)
                break;
        end
        @(posedge clk);
        predict_quad(d);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        wait (triangles_due.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    // One register write; the enable drops again before the next write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SPC_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_GRID_COLUMNS)
            columns_q = (v & 16'h7FF) > GRID_LIMIT ? GRID_LIMIT : (v & 16'h7FF);
        else if (idx == CFG_SPACING_X)
            step_x_q = v;
        else if (idx == CFG_SPACING_Z)
            step_z_q = v;
        @(posedge clk);
    endtask

    task automatic random_quad();
        logic [15:0] base;
        logic [15:0] h[4];
        base = $urandom;
        for (int i = 0; i < 4; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                h[i] = base + $urandom_range(0, 15);
            else
                h[i] = $urandom;
        end
        send_quad($urandom_range(0, 1023), $urandom_range(0, 1023), h[0], h[1],
                  h[2], h[3]);
    endtask

    // Corners of the fields at reset configuration
    task automatic test_directed();
        send_quad(10'd0, 10'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_quad(10'd1022, 10'd1022, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_quad(10'd1023, 10'd1023, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
        send_quad(10'd0, 10'd1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
        send_quad(10'd5, 10'd3, 16'h0100, 16'h0200, 16'h0300, 16'h0400);
        send_quad(10'h155, 10'h2AA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_quad(10'h2AA, 10'h155, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        send_quad(10'd7, 10'd9, 16'd1, 16'd0, 16'd0, 16'd1);
        drain_results();
    endtask

    // Register extremes: zero and maximum spacing, column saturation, zero columns, unused index
    task automatic test_config_extremes();
        write_reg(CFG_SPACING_X, 16'd0);
        send_quad(10'd3, 10'd4, 16'd100, 16'd900, 16'd50, 16'd7);
        drain_results();
        write_reg(CFG_SPACING_X, 16'hFFFF);
        write_reg(CFG_SPACING_Z, 16'd0);
        send_quad(10'd3, 10'd4, 16'd100, 16'd900, 16'd50, 16'd7);
        drain_results();
        write_reg(CFG_SPACING_Z, 16'hFFFF);
        write_reg(CFG_GRID_COLUMNS, 16'd2047);
        send_quad(10'd1023, 10'd1023, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
        send_quad(10'd1, 10'd2, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        drain_results();
        write_reg(CFG_GRID_COLUMNS, 16'd0);
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_quad(10'd9, 10'd9, 16'd1, 16'd2, 16'd3, 16'd4);
        drain_results();
        write_reg(CFG_GRID_COLUMNS, 16'd1);
        write_reg(CFG_SPACING_X, 16'd1);
        write_reg(CFG_SPACING_Z, 16'd1);
        send_quad(10'd12, 10'd30, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
        drain_results();
    endtask

    // Random quads over several register settings
    task automatic test_random();
        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(CFG_GRID_COLUMNS, phase == 0 ? 16'd1024 : $urandom_range(0, 2047));
            write_reg(CFG_SPACING_X, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 1024));
            write_reg(CFG_SPACING_Z, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 1024));
            quiet = (phase == 2);
            for (int i = 0; i < 200; i++)
            begin
                random_quad();
                if (i == 100)
                begin
                    // hold off until the pipeline is empty
                    s_axis_tvalid <= 1'b0;
                    wait (triangles_due.size() == 0);
                    @(posedge clk);
                end
            end
            quiet = 0;
            drain_results();
        end
    endtask

    // Result checker, receiver stalls and watchdog
    initial
    begin
        triangle_t exp_t;
        triangle_t got;
        m_axis_tready = 1'b0;
        stall_cycles = 0;
        forever
        begin
            @(negedge clk);
            in_hit  = s_axis_tvalid && s_axis_tready;
            out_hit = m_axis_tvalid && m_axis_tready;
            got.first  = m_axis_tdata[19:0];
            got.second = m_axis_tdata[39:20];
            got.third  = m_axis_tdata[59:40];
            got.nx     = m_axis_tdata[75:60];
            got.ny     = m_axis_tdata[91:76];
            got.nz     = m_axis_tdata[107:92];
            got.last   = m_axis_tlast;
            @(posedge clk);
            m_axis_tready <= rst_n && (quiet != 0 || $urandom_range(0, 99) >= 8);
            if (out_hit)
            begin
                if (triangles_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected triangle %p", got);
                end
                else
                begin
                    exp_t = triangles_due.pop_front();
                    if (got != exp_t)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("triangle differs: expected %p actual %p", exp_t, got);
                    end
                end
            end
            stall_cycles = (in_hit || out_hit || !rst_n) ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("grid_quad_triangulate_normal_top: mismatch");
                $finish;
            end
        end
    end

    // Test sequence
    initial
    begin
        cfg_we = 1'b0;
        cfg_index = CFG_GRID_COLUMNS;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        mismatch_count = 0;
        quiet = 0;
        columns_q = 2;
        step_x_q = 256;
        step_z_q = 256;
        wait (rst_n);
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_random();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && triangles_due.size() == 0)
            $display("grid_quad_triangulate_normal_top: match");
        else
            $display("grid_quad_triangulate_normal_top: mismatch");
        $finish;
    end

endmodule
